>>> hdl/sadbm_pkg.sv
// Shared types, widths and constants of the descriptor SAD best-match block.
// Used by the input queue, the match datapath and the top level.
// No dependencies.
package sadbm_pkg;

    localparam int DESC_WORDS     = 4;
    localparam int BYTES_PER_WORD = 8;
    localparam int BYTE_W         = 8;
    localparam int WORD_W         = 64;
    localparam int POINT_W        = 16;
    localparam int INDEX_W        = 12;
    localparam int COST_W         = 13;
    localparam int GROUP_SUM_W    = 11;
    localparam int COUNT_W        = 16;
    localparam int THRESH_W       = 13;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    typedef enum logic
    {
        MODE_LOAD      = 1'b0,
        MODE_CANDIDATE = 1'b1
    } mode_t;

    // Register index, taken from the word-aligned part of the address.
    localparam logic [ADDR_W-3:0] REG_THRESHOLD = '0;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 13'd100;
    localparam logic [COUNT_W-1:0]  COUNT_MAX       = '1;

    typedef logic [DESC_WORDS-1:0][WORD_W-1:0] desc_t;

    typedef struct packed
    {
        logic                is_load;
        desc_t               desc;
        logic [POINT_W-1:0]  point;
        logic [INDEX_W-1:0]  index;
        logic                last;
    } item_t;

    // Sum of absolute byte differences over one 64-bit descriptor word.
    function automatic logic [GROUP_SUM_W-1:0] group_sad(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b
    );
        logic [GROUP_SUM_W-1:0] sum;
        logic [BYTE_W-1:0]      x;
        logic [BYTE_W-1:0]      y;
        sum = '0;
        for (int i = 0; i < BYTES_PER_WORD; i++)
        begin
            x = a[i*BYTE_W +: BYTE_W];
            y = b[i*BYTE_W +: BYTE_W];
            if (x > y)
            begin
                sum = sum + GROUP_SUM_W'(x - y);
            end
            else
            begin
                sum = sum + GROUP_SUM_W'(y - x);
            end
        end
        return sum;
    endfunction

endpackage

>>> hdl/descriptor_sad_best_match.sv
// Matches a stored 32-byte reference descriptor against a stream of candidate
// words by sum of absolute byte differences, keeping the earliest lowest cost;
// the word marked last yields one result with the best index and cost, a match
// flag when the cost is below match_threshold, and a saturating match count.
// The block takes one input word per clock while its queue is not full: the
// queue in the front end absorbs short output stalls, and the datapath is three
// stages (per-word sums, total, then running minimum and registered output
// updated together).
// Depends on sadbm_pkg, sadbm_front and sadbm_back.
module descriptor_sad_best_match
    import sadbm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [WORD_W-1:0]    desc_word_0,
    input  logic [WORD_W-1:0]    desc_word_1,
    input  logic [WORD_W-1:0]    desc_word_2,
    input  logic [WORD_W-1:0]    desc_word_3,
    input  logic [POINT_W-1:0]   point_id,
    input  logic [INDEX_W-1:0]   candidate_index,
    input  logic                 last_candidate,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 match_valid,
    output logic [POINT_W-1:0]   matched_point,
    output logic [INDEX_W-1:0]   best_index,
    output logic [COST_W-1:0]    best_cost,
    output logic [COUNT_W-1:0]   match_total
);

    logic [THRESH_W-1:0]  threshold_reg;
    logic                 sel_threshold;
    logic                 item_valid;
    logic                 item_ready;
    item_t                item;

    assign pready        = 1'b1;
    assign sel_threshold = (paddr[ADDR_W-1:2] == REG_THRESHOLD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_threshold)
        begin
            threshold_reg <= pwdata[THRESH_W-1:0];
        end
    end

    assign prdata = sel_threshold ? DATA_W'(threshold_reg) : '0;

    sadbm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .desc_word_0     (desc_word_0),
        .desc_word_1     (desc_word_1),
        .desc_word_2     (desc_word_2),
        .desc_word_3     (desc_word_3),
        .point_id        (point_id),
        .candidate_index (candidate_index),
        .last_candidate  (last_candidate),
        .item_valid      (item_valid),
        .item            (item),
        .item_ready      (item_ready)
    );

    sadbm_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item            (item),
        .item_ready      (item_ready),
        .match_threshold (threshold_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .match_valid     (match_valid),
        .matched_point   (matched_point),
        .best_index      (best_index),
        .best_cost       (best_cost),
        .match_total     (match_total)
    );

endmodule

>>> hdl/sadbm_front.sv
// Front end: accepts input words, classifies them as loads or candidates
// and holds them in a short queue for the match datapath. Uses sadbm_pkg.
module sadbm_front
    import sadbm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [WORD_W-1:0]    desc_word_0,
    input  logic [WORD_W-1:0]    desc_word_1,
    input  logic [WORD_W-1:0]    desc_word_2,
    input  logic [WORD_W-1:0]    desc_word_3,
    input  logic [POINT_W-1:0]   point_id,
    input  logic [INDEX_W-1:0]   candidate_index,
    input  logic                 last_candidate,
    output logic                 item_valid,
    output item_t                item,
    input  logic                 item_ready
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]    PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [COUNT_QW-1:0] Q_FULL   = COUNT_QW'(QUEUE_DEPTH);

    item_t                queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [COUNT_QW-1:0]  count_reg;
    item_t                in_item;
    logic                 push;
    logic                 pop;

    always_comb
    begin
        in_item.is_load = (mode_t'(mode) == MODE_LOAD);
        in_item.desc    = {desc_word_3, desc_word_2, desc_word_1, desc_word_0};
        in_item.point   = point_id;
        in_item.index   = candidate_index;
        in_item.last    = last_candidate;
    end

    assign in_ready   = (count_reg != Q_FULL);
    assign item_valid = (count_reg != '0);
    assign item       = queue_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/sadbm_back.sv
// Back end: SAD pipeline against the stored reference, running minimum,
// match decision and the output register. Uses sadbm_pkg.
module sadbm_back
    import sadbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  item_t                item,
    output logic                 item_ready,
    input  logic [THRESH_W-1:0]  match_threshold,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 match_valid,
    output logic [POINT_W-1:0]   matched_point,
    output logic [INDEX_W-1:0]   best_index,
    output logic [COST_W-1:0]    best_cost,
    output logic [COUNT_W-1:0]   match_total
);

    // Stage 1: per-word partial sums.
    desc_t                                  ref_desc_reg;
    logic                                   s1_valid_reg;
    logic                                   s1_is_load_reg;
    logic                                   s1_last_reg;
    logic [POINT_W-1:0]                     s1_point_reg;
    logic [INDEX_W-1:0]                     s1_index_reg;
    logic [DESC_WORDS-1:0][GROUP_SUM_W-1:0] s1_sum_reg;
    logic [DESC_WORDS-1:0][GROUP_SUM_W-1:0] group_sum;

    // Stage 2: full cost.
    logic                s2_valid_reg;
    logic                s2_is_load_reg;
    logic                s2_last_reg;
    logic [POINT_W-1:0]  s2_point_reg;
    logic [INDEX_W-1:0]  s2_index_reg;
    logic [COST_W-1:0]   s2_cost_reg;
    logic [COST_W-1:0]   total_cost;

    // Running minimum and result.
    logic [POINT_W-1:0]  ref_point_reg, ref_point_next;
    logic [COST_W-1:0]   min_cost_reg, min_cost_next;
    logic [INDEX_W-1:0]  min_index_reg, min_index_next;
    logic                have_reg, have_next;
    logic [COUNT_W-1:0]  counter_reg, counter_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_match_reg;
    logic [POINT_W-1:0]  out_point_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [COST_W-1:0]   out_cost_reg;

    logic                out_free;
    logic                s2_emit;
    logic                s2_go;
    logic                s2_take;
    logic                s1_take;
    logic                better;
    logic [COST_W-1:0]   cand_cost;
    logic [INDEX_W-1:0]  cand_index;
    logic                match;

    // A result only waits when the output word has not been taken yet.
    assign out_free   = !out_valid_reg || out_ready;
    assign s2_emit    = s2_valid_reg && !s2_is_load_reg && s2_last_reg;
    assign s2_go      = s2_valid_reg && (!s2_emit || out_free);
    assign s2_take    = !s2_valid_reg || s2_go;
    assign s1_take    = !s1_valid_reg || s2_take;
    assign item_ready = s1_take;

    always_comb
    begin
        for (int w = 0; w < DESC_WORDS; w++)
        begin
            group_sum[w] = group_sad(ref_desc_reg[w], item.desc[w]);
        end
    end

    always_comb
    begin
        total_cost = '0;
        for (int w = 0; w < DESC_WORDS; w++)
        begin
            total_cost = total_cost + COST_W'(s1_sum_reg[w]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_is_load_reg <= item.is_load;
            s1_last_reg    <= item.last;
            s1_point_reg   <= item.point;
            s1_index_reg   <= item.index;
            s1_sum_reg     <= group_sum;
        end
        if (s2_take)
        begin
            s2_is_load_reg <= s1_is_load_reg;
            s2_last_reg    <= s1_last_reg;
            s2_point_reg   <= s1_point_reg;
            s2_index_reg   <= s1_index_reg;
            s2_cost_reg    <= total_cost;
        end
        if (s2_go && s2_emit)
        begin
            out_match_reg <= match;
            out_point_reg <= ref_point_reg;
            out_index_reg <= cand_index;
            out_cost_reg  <= cand_cost;
        end
    end

    // The reference changes as a load leaves the queue, so every later
    // candidate is scored against it and every earlier one is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_desc_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_valid && s1_take && item.is_load)
            begin
                ref_desc_reg <= item.desc;
            end
            if (s1_take)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_comb
    begin
        better     = !have_reg || (s2_cost_reg < min_cost_reg);
        cand_cost  = better ? s2_cost_reg : min_cost_reg;
        cand_index = better ? s2_index_reg : min_index_reg;
        match      = ({1'b0, cand_cost} < {1'b0, match_threshold});

        ref_point_next = ref_point_reg;
        min_cost_next  = min_cost_reg;
        min_index_next = min_index_reg;
        have_next      = have_reg;
        counter_next   = counter_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (s2_go)
        begin
            if (s2_is_load_reg)
            begin
                ref_point_next = s2_point_reg;
                min_cost_next  = '1;
                min_index_next = '0;
                have_next      = 1'b0;
            end
            else if (s2_last_reg)
            begin
                if (match && (counter_reg != COUNT_MAX))
                begin
                    counter_next = counter_reg + 1'b1;
                end
                out_valid_next = 1'b1;
                min_cost_next  = '1;
                min_index_next = '0;
                have_next      = 1'b0;
            end
            else
            begin
                min_cost_next  = cand_cost;
                min_index_next = cand_index;
                have_next      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_point_reg <= '0;
            min_cost_reg  <= '1;
            min_index_reg <= '0;
            have_reg      <= 1'b0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ref_point_reg <= ref_point_next;
            min_cost_reg  <= min_cost_next;
            min_index_reg <= min_index_next;
            have_reg      <= have_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign match_valid   = out_match_reg;
    assign matched_point = out_point_reg;
    assign best_index    = out_index_reg;
    assign best_cost     = out_cost_reg;
    assign match_total   = counter_reg;

endmodule
